// ===== sv/gqve_pkg.sv =====
package gqve_pkg;

    localparam int PIX_W      = 24;
    localparam int TEX_W      = 16;
    localparam int SCALE_W    = 16;
    localparam int FRAC_SHIFT = 12;
    localparam int PROD_W     = PIX_W + SCALE_W + 1;
    localparam int SCALED_W   = PROD_W - FRAC_SHIFT;
    localparam int SUM_W      = SCALED_W + 2;
    localparam int SLOT_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 5 * PIX_W + 4 * TEX_W;
    localparam int OUT_DATA_W = 2 * PIX_W + 2 * TEX_W;

    localparam logic [SLOT_W-1:0]  LAST_SLOT   = 3'd5;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;

    typedef logic signed [PIX_W-1:0]    pix_t;
    typedef logic signed [SCALED_W-1:0] scaled_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [TEX_W-1:0]           tex_t;

    // bit 1: right edge, bit 0: bottom edge
    function automatic logic [1:0] corner_of(input logic [SLOT_W-1:0] slot);
        logic [1:0] c;
        case (slot)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd1;
            3'd2:    c = 2'd2;
            3'd3:    c = 2'd1;
            3'd4:    c = 2'd2;
            3'd5:    c = 2'd3;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

    function automatic pix_t sat_pix(input sum_t v);
        pix_t r;
        if ((&v[SUM_W-1:PIX_W-1]) || !(|v[SUM_W-1:PIX_W-1]))
        begin
            r = v[PIX_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            r = {1'b1, {(PIX_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(PIX_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic tex_t sat_tex(input tex_t a, input tex_t b);
        logic [TEX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TEX_W] ? {TEX_W{1'b1}} : s[TEX_W-1:0];
    endfunction

    function automatic scaled_t scale_pix(input pix_t p, input logic [SCALE_W-1:0] k);
        logic signed [PROD_W-1:0] prod;
        prod = PROD_W'(p) * $signed({1'b0, k});
        return prod[PROD_W-1:FRAC_SHIFT];
    endfunction

endpackage

// ===== sv/glyph_quad_vertex_emitter.sv =====
// channel  | dir | handshake               | content
// s_axis   | in  | s_tvalid / s_tready     | one glyph: box, advance, atlas rectangle, first flag
// m_axis   | out | m_tvalid / m_tready     | one vertex: position, atlas coordinate, slot, last
// cfg      | in  | cfg_valid / cfg_ready   | register index and write data
//
// each glyph gives six vertex transfers on m_axis
// a glyph is taken every cycle a stage is free, so glyphs follow back to back
// from input transfer to first vertex a glyph passes the input, scaled and corner registers in turn
// reset clears pen x and the registers to origin 0, 0 and scale 1.0
// a stall on m_axis holds the current vertex and fills the stages behind it
module glyph_quad_vertex_emitter
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // offset_x, offset_y, box_width, box_height, advance, atlas_u, atlas_v, atlas_w, atlas_h
    input  logic [gqve_pkg::IN_DATA_W-1:0]      s_tdata,
    // first
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pos_x, pos_y, tex_u, tex_v
    output logic [gqve_pkg::OUT_DATA_W-1:0]     m_tdata,
    // vertex_slot
    output logic [gqve_pkg::SLOT_W-1:0]         m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gqve_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gqve_pkg::PIX_W-1:0]          cfg_data
);

    localparam int PW = gqve_pkg::PIX_W;
    localparam int TW = gqve_pkg::TEX_W;

    gqve_pkg::pix_t                    origin_x_reg;
    gqve_pkg::pix_t                    origin_y_reg;
    logic [gqve_pkg::SCALE_W-1:0]      scale_reg;
    gqve_pkg::pix_t                    pen_reg;
    gqve_pkg::pix_t                    pen_next;

    // input stage
    logic                              a_valid_reg;
    logic                              a_first_reg;
    gqve_pkg::pix_t                    a_off_x_reg;
    gqve_pkg::pix_t                    a_off_y_reg;
    gqve_pkg::pix_t                    a_box_w_reg;
    gqve_pkg::pix_t                    a_box_h_reg;
    gqve_pkg::pix_t                    a_adv_reg;
    gqve_pkg::tex_t                    a_u_reg;
    gqve_pkg::tex_t                    a_v_reg;
    gqve_pkg::tex_t                    a_w_reg;
    gqve_pkg::tex_t                    a_h_reg;

    // scaled stage
    logic                              b_valid_reg;
    logic                              b_first_reg;
    gqve_pkg::scaled_t                 b_off_x_reg;
    gqve_pkg::scaled_t                 b_off_y_reg;
    gqve_pkg::scaled_t                 b_box_w_reg;
    gqve_pkg::scaled_t                 b_box_h_reg;
    gqve_pkg::scaled_t                 b_adv_reg;
    gqve_pkg::tex_t                    b_u_reg;
    gqve_pkg::tex_t                    b_v_reg;
    gqve_pkg::tex_t                    b_w_reg;
    gqve_pkg::tex_t                    b_h_reg;

    // corner stage
    logic                              c_valid_reg;
    logic [gqve_pkg::SLOT_W-1:0]       slot_reg;
    logic [gqve_pkg::SLOT_W-1:0]       slot_next;
    gqve_pkg::pix_t                    x0_reg;
    gqve_pkg::pix_t                    x1_reg;
    gqve_pkg::pix_t                    y0_reg;
    gqve_pkg::pix_t                    y1_reg;
    gqve_pkg::tex_t                    u0_reg;
    gqve_pkg::tex_t                    u1_reg;
    gqve_pkg::tex_t                    v0_reg;
    gqve_pkg::tex_t                    v1_reg;

    logic                              a_load;
    logic                              b_load;
    logic                              c_load;
    logic                              out_xfer;
    logic                              out_done;
    gqve_pkg::pix_t                    pen_base;
    gqve_pkg::sum_t                    gx;
    gqve_pkg::sum_t                    gy;
    logic [1:0]                        corner;

    assign cfg_ready = 1'b1;

    assign out_xfer = m_tvalid && m_tready;
    assign out_done = out_xfer && (slot_reg == gqve_pkg::LAST_SLOT);
    assign c_load   = b_valid_reg && (!c_valid_reg || out_done);
    assign b_load   = a_valid_reg && (!b_valid_reg || c_load);
    assign s_tready = !a_valid_reg || b_load;
    assign a_load   = s_tvalid && s_tready;

    assign pen_base = b_first_reg ? origin_x_reg : pen_reg;
    assign gx = gqve_pkg::sum_t'(pen_base) + gqve_pkg::sum_t'(b_off_x_reg);
    assign gy = gqve_pkg::sum_t'(origin_y_reg) + gqve_pkg::sum_t'(b_off_y_reg);
    assign pen_next = gqve_pkg::sat_pix(gqve_pkg::sum_t'(pen_base)
                                        + gqve_pkg::sum_t'(b_adv_reg));
    assign slot_next = (slot_reg == gqve_pkg::LAST_SLOT) ? '0 : slot_reg + 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            scale_reg    <= gqve_pkg::SCALE_RESET;
            pen_reg      <= '0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            slot_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gqve_pkg::CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                    gqve_pkg::CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                    gqve_pkg::CFG_SCALE:    scale_reg    <= cfg_data[gqve_pkg::SCALE_W-1:0];
                    default:                ;
                endcase
            end
            if (a_load)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (b_load)
            begin
                a_valid_reg <= 1'b0;
            end
            if (b_load)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (c_load)
            begin
                b_valid_reg <= 1'b0;
            end
            if (c_load)
            begin
                c_valid_reg <= 1'b1;
                pen_reg     <= pen_next;
            end
            else if (out_done)
            begin
                c_valid_reg <= 1'b0;
            end
            if (out_xfer)
            begin
                slot_reg <= slot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_first_reg <= s_tuser;
            a_off_x_reg <= s_tdata[0*PW +: PW];
            a_off_y_reg <= s_tdata[1*PW +: PW];
            a_box_w_reg <= s_tdata[2*PW +: PW];
            a_box_h_reg <= s_tdata[3*PW +: PW];
            a_adv_reg   <= s_tdata[4*PW +: PW];
            a_u_reg     <= s_tdata[5*PW + 0*TW +: TW];
            a_v_reg     <= s_tdata[5*PW + 1*TW +: TW];
            a_w_reg     <= s_tdata[5*PW + 2*TW +: TW];
            a_h_reg     <= s_tdata[5*PW + 3*TW +: TW];
        end
        if (b_load)
        begin
            b_first_reg <= a_first_reg;
            b_off_x_reg <= gqve_pkg::scale_pix(a_off_x_reg, scale_reg);
            b_off_y_reg <= gqve_pkg::scale_pix(a_off_y_reg, scale_reg);
            b_box_w_reg <= gqve_pkg::scale_pix(a_box_w_reg, scale_reg);
            b_box_h_reg <= gqve_pkg::scale_pix(a_box_h_reg, scale_reg);
            b_adv_reg   <= gqve_pkg::scale_pix(a_adv_reg, scale_reg);
            b_u_reg     <= a_u_reg;
            b_v_reg     <= a_v_reg;
            b_w_reg     <= a_w_reg;
            b_h_reg     <= a_h_reg;
        end
        if (c_load)
        begin
            x0_reg <= gqve_pkg::sat_pix(gx);
            x1_reg <= gqve_pkg::sat_pix(gx + gqve_pkg::sum_t'(b_box_w_reg));
            y0_reg <= gqve_pkg::sat_pix(gy);
            y1_reg <= gqve_pkg::sat_pix(gy + gqve_pkg::sum_t'(b_box_h_reg));
            u0_reg <= b_u_reg;
            u1_reg <= gqve_pkg::sat_tex(b_u_reg, b_w_reg);
            v0_reg <= b_v_reg;
            v1_reg <= gqve_pkg::sat_tex(b_v_reg, b_h_reg);
        end
    end

    assign corner   = gqve_pkg::corner_of(slot_reg);
    assign m_tvalid = c_valid_reg;
    assign m_tuser  = slot_reg;
    assign m_tlast  = (slot_reg == gqve_pkg::LAST_SLOT);
    assign m_tdata  = {corner[0] ? v1_reg : v0_reg,
                       corner[1] ? u1_reg : u0_reg,
                       corner[0] ? y1_reg : y0_reg,
                       corner[1] ? x1_reg : x0_reg};

endmodule

// ===== sv/gqve_checker.sv =====
module gqve_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [gqve_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic [gqve_pkg::SLOT_W-1:0]         m_tuser,
    input  logic                                m_tlast
);

    // stalled vertex holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled vertex changed");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == gqve_pkg::LAST_SLOT)))
        else $error("tlast not on the sixth vertex");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= gqve_pkg::LAST_SLOT))
        else $error("vertex slot out of range");

    // the rest of a glyph follows without a gap
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast)
        |=> (m_tvalid && (m_tuser == gqve_pkg::SLOT_W'($past(m_tuser) + 3'd1))))
        else $error("vertex slot sequence broken");

    // a new glyph starts at slot zero
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (m_tuser == '0))
        else $error("glyph did not start at slot zero");

endmodule

bind glyph_quad_vertex_emitter gqve_checker u_gqve_checker (.*);

// ===== dv/tb_glyph_quad_vertex_emitter.sv =====
`timescale 1ns / 1ps

module tb_glyph_quad_vertex_emitter;

    localparam int VERTS   = 6;
    localparam int PIX_MAX = 8388607;
    localparam int PIX_MIN = -8388608;
    localparam logic [1:0] CORNER [VERTS] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3};

    typedef struct {
        logic           first;
        gqve_pkg::pix_t off_x;
        gqve_pkg::pix_t off_y;
        gqve_pkg::pix_t box_w;
        gqve_pkg::pix_t box_h;
        gqve_pkg::pix_t adv;
        gqve_pkg::tex_t u;
        gqve_pkg::tex_t v;
        gqve_pkg::tex_t w;
        gqve_pkg::tex_t h;
    } glyph_t;

    typedef struct {
        gqve_pkg::pix_t              px;
        gqve_pkg::pix_t              py;
        gqve_pkg::tex_t              tu;
        gqve_pkg::tex_t              tv;
        logic [gqve_pkg::SLOT_W-1:0] slot;
        logic                        last;
    } vertex_t;

    class vertex_board;
        gqve_pkg::pix_t               origin_x;
        gqve_pkg::pix_t               origin_y;
        logic [gqve_pkg::SCALE_W-1:0] scale_q;
        gqve_pkg::pix_t               pen;
        vertex_t                      pending_q[$];
        int                           errors;

        function new();
            origin_x = '0;
            origin_y = '0;
            scale_q  = gqve_pkg::SCALE_RESET;
            pen      = '0;
            errors   = 0;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void set_reg(logic [gqve_pkg::CFG_IDX_W-1:0] idx,
                              logic [gqve_pkg::PIX_W-1:0] data);
            case (idx)
                gqve_pkg::CFG_ORIGIN_X: origin_x = gqve_pkg::pix_t'(data);
                gqve_pkg::CFG_ORIGIN_Y: origin_y = gqve_pkg::pix_t'(data);
                gqve_pkg::CFG_SCALE:    scale_q  = data[gqve_pkg::SCALE_W-1:0];
                default:                ;
            endcase
        endfunction

        // floor of p * scale, back to q.8
        function longint floor_scaled(gqve_pkg::pix_t p);
            longint prod;
            prod = longint'(p) * longint'(scale_q);
            return prod >>> gqve_pkg::FRAC_SHIFT;
        endfunction

        function gqve_pkg::pix_t clamp_pix(longint s);
            if (s > PIX_MAX)
                return gqve_pkg::pix_t'(PIX_MAX);
            if (s < PIX_MIN)
                return gqve_pkg::pix_t'(PIX_MIN);
            return gqve_pkg::pix_t'(s);
        endfunction

        function gqve_pkg::tex_t clamp_tex(int unsigned s);
            return (s > 32'hFFFF) ? 16'hFFFF : gqve_pkg::tex_t'(s);
        endfunction

        function void note_glyph(glyph_t g);
            longint  gx;
            longint  gy;
            longint  dw;
            longint  dh;
            vertex_t e;
            logic [1:0] c;
            if (g.first)
                pen = origin_x;
            gx = longint'(pen) + floor_scaled(g.off_x);
            gy = longint'(origin_y) + floor_scaled(g.off_y);
            dw = floor_scaled(g.box_w);
            dh = floor_scaled(g.box_h);
            for (int k = 0; k < VERTS; k++)
            begin
                c      = CORNER[k];
                e.px   = clamp_pix(c[1] ? gx + dw : gx);
                e.py   = clamp_pix(c[0] ? gy + dh : gy);
                e.tu   = c[1] ? clamp_tex(32'(g.u) + 32'(g.w)) : g.u;
                e.tv   = c[0] ? clamp_tex(32'(g.v) + 32'(g.h)) : g.v;
                e.slot = gqve_pkg::SLOT_W'(k);
                e.last = (k == VERTS - 1);
                pending_q.push_back(e);
            end
            pen = clamp_pix(longint'(pen) + floor_scaled(g.adv));
        endfunction

        task check_vertex(vertex_t got);
            vertex_t want;
            if (pending_q.size() == 0)
            begin
                report($sformatf("vertex slot %0d with no glyph pending", got.slot));
                return;
            end
            want = pending_q.pop_front();
            if (got.px !== want.px)
                report($sformatf("slot %0d pos_x got %0d want %0d", want.slot, got.px, want.px));
            if (got.py !== want.py)
                report($sformatf("slot %0d pos_y got %0d want %0d", want.slot, got.py, want.py));
            if (got.tu !== want.tu)
                report($sformatf("slot %0d tex_u got %0d want %0d", want.slot, got.tu, want.tu));
            if (got.tv !== want.tv)
                report($sformatf("slot %0d tex_v got %0d want %0d", want.slot, got.tv, want.tv));
            if (got.slot !== want.slot)
                report($sformatf("vertex_slot got %0d want %0d", got.slot, want.slot));
            if (got.last !== want.last)
                report($sformatf("slot %0d last got %0b want %0b", want.slot, got.last,
                                 want.last));
        endtask
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [gqve_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [gqve_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [gqve_pkg::SLOT_W-1:0]     m_tuser;
    logic                            m_tlast;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [gqve_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gqve_pkg::PIX_W-1:0]      cfg_data;

    vertex_board sb = new();
    int idle_pct  = 0;
    int stall_pct = 0;

    glyph_quad_vertex_emitter uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
    begin
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        glyph_t  g;
        vertex_t got;
        if (rst_n && s_tvalid && s_tready)
        begin
            g.first = s_tuser;
            {g.h, g.w, g.v, g.u, g.adv, g.box_h, g.box_w, g.off_y, g.off_x} = s_tdata;
            sb.note_glyph(g);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            {got.tv, got.tu, got.py, got.px} = m_tdata;
            got.slot = m_tuser;
            got.last = m_tlast;
            sb.check_vertex(got);
        end
    end

    function automatic glyph_t mk(logic first, int ox, int oy, int bw, int bh, int adv,
                                  int u, int v, int w, int h);
        glyph_t g;
        g.first = first;
        g.off_x = gqve_pkg::pix_t'(ox);
        g.off_y = gqve_pkg::pix_t'(oy);
        g.box_w = gqve_pkg::pix_t'(bw);
        g.box_h = gqve_pkg::pix_t'(bh);
        g.adv   = gqve_pkg::pix_t'(adv);
        g.u     = gqve_pkg::tex_t'(u);
        g.v     = gqve_pkg::tex_t'(v);
        g.w     = gqve_pkg::tex_t'(w);
        g.h     = gqve_pkg::tex_t'(h);
        return g;
    endfunction

    function automatic gqve_pkg::pix_t rand_pix();
        case ($urandom_range(9))
            0:       return gqve_pkg::pix_t'(PIX_MAX);
            1:       return gqve_pkg::pix_t'(PIX_MIN);
            2, 3, 4: return gqve_pkg::pix_t'($urandom);
            default: return gqve_pkg::pix_t'(int'($urandom_range(65535)) - 32768);
        endcase
    endfunction

    function automatic gqve_pkg::tex_t rand_tex();
        case ($urandom_range(7))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            2:       return gqve_pkg::tex_t'($urandom_range(4095));
            default: return gqve_pkg::tex_t'($urandom);
        endcase
    endfunction

    task automatic send_glyph(glyph_t g);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= g.first;
        s_tdata  <= {g.h, g.w, g.v, g.u, g.adv, g.box_h, g.box_w, g.off_y, g.off_x};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // hold the sender until every vertex owed has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_regs(gqve_pkg::pix_t ox, gqve_pkg::pix_t oy,
                              logic [gqve_pkg::SCALE_W-1:0] sc);
        logic [gqve_pkg::CFG_IDX_W-1:0] idx [3];
        logic [gqve_pkg::PIX_W-1:0]     val [3];
        idx = '{gqve_pkg::CFG_ORIGIN_X, gqve_pkg::CFG_ORIGIN_Y, gqve_pkg::CFG_SCALE};
        val = '{ox, oy, gqve_pkg::PIX_W'(sc)};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(int n, int idle, int stall);
        glyph_t g;
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            g.first = ($urandom_range(99) < 12);
            g.off_x = rand_pix();
            g.off_y = rand_pix();
            g.box_w = rand_pix();
            g.box_h = rand_pix();
            g.adv   = ($urandom_range(3) == 0) ? rand_pix()
                                               : gqve_pkg::pix_t'($urandom_range(12288));
            g.u     = rand_tex();
            g.v     = rand_tex();
            g.w     = rand_tex();
            g.h     = rand_tex();
            send_glyph(g);
            if ($urandom_range(39) == 0)
                drain();
        end
        drain();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= gqve_pkg::CFG_ORIGIN_X;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: scale 1.0, origin 0, 0
        send_glyph(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_glyph(mk(0, 256, -512, 2048, 3072, 2560, 100, 200, 300, 400));
        send_glyph(mk(0, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, 0,
                      65535, 65535, 65535, 65535));
        send_glyph(mk(0, PIX_MIN, PIX_MIN, PIX_MIN, PIX_MIN, 0, 0, 0, 0, 0));
        send_glyph(mk(0, 0, 0, -1024, -768, 0, 60000, 60000, 5535, 5536));
        send_glyph(mk(1, -1, -1, 1, 1, PIX_MAX, 1, 1, 65534, 65534));
        send_glyph(mk(0, 0, 0, 0, 0, PIX_MAX, 12, 34, 56, 78));
        send_glyph(mk(0, -3, 5, 0, 0, PIX_MIN, 0, 65535, 65535, 0));
        send_glyph(mk(0, 0, 0, 0, 0, PIX_MIN, 65535, 0, 0, 65535));
        send_glyph(mk(1, 7, -7, 512, 512, 1024, 1000, 2000, 3000, 4000));
        send_glyph(mk(0, 'h555555, 'hAAAAAA, 'h555555, 'hAAAAAA, 'h555555,
                      'h5555, 'hAAAA, 'h5555, 'hAAAA));
        send_glyph(mk(0, 'hAAAAAA, 'h555555, 'hAAAAAA, 'h555555, 'hAAAAAA,
                      'hAAAA, 'h5555, 'hAAAA, 'h5555));
        run_phase(53, 0, 0);

        write_regs(gqve_pkg::pix_t'(PIX_MIN), gqve_pkg::pix_t'(PIX_MAX), 16'hFFFF);
        idle_pct = 74;
        send_glyph(mk(1, -1, -1, 1, -1, -1, 10, 20, 30, 40));
        send_glyph(mk(0, PIX_MAX, PIX_MIN, PIX_MAX, PIX_MIN, PIX_MAX,
                      65535, 65535, 1, 1));
        send_glyph(mk(0, 1, 1, 1, 1, 1, 0, 0, 0, 0));
        run_phase(53, 74, 0);

        write_regs(gqve_pkg::pix_t'(PIX_MAX), gqve_pkg::pix_t'(PIX_MIN), 16'h0000);
        stall_pct = 74;
        send_glyph(mk(1, PIX_MAX, PIX_MIN, PIX_MIN, PIX_MAX, PIX_MAX,
                      65535, 65535, 65535, 65535));
        run_phase(53, 0, 74);

        write_regs(rand_pix(), rand_pix(), 16'd2048);
        run_phase(53, 28, 28);

        write_regs(rand_pix(), rand_pix(), gqve_pkg::SCALE_W'($urandom));
        run_phase(53, 0, 0);

        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
